@@ hw/rtl/rc4_pkg.sv @@
// Shared types and constants for the RC4 stream cipher block.
package rc4_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned KEY_LEN_W     = 9;
  localparam int unsigned DROP_W        = 16;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned KEY_BYTES_DEF = 256;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 9'd16;
  localparam logic [DROP_W-1:0]    DROP_RST    = 16'd512;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_INIT = 2'd1,
    CMD_DATA = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 1'b0,
    CFG_DROP_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INIT,
    OP_DATA,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

@@ hw/rtl/rc4_if.sv @@
// Request and result channel interfaces of the RC4 stream cipher.
interface rc4_req_if
  import rc4_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] key_index;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, command, key_index, data_byte, input ready);
  modport sink (input valid, command, key_index, data_byte, output ready);
endinterface

interface rc4_rsp_if
  import rc4_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;
  logic              is_data;

  modport source (output valid, result_byte, is_data, input ready);
  modport sink (input valid, result_byte, is_data, output ready);
endinterface

@@ hw/rtl/rc4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rc4_front.sv @@
// Request front end: accepts and classifies requests into a two-entry queue.
module rc4_front
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rc4_req_if.sink    req_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  localparam int unsigned QDEPTH = 2;

  item_t      fifo_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      cls;

  assign req_i.ready = (cnt_q != 2'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;

  // An out-of-range key load is kept as an acknowledge-only request.
  always_comb begin
    cls.key_index = req_i.key_index;
    cls.data      = req_i.data_byte;
    unique case (cmd_e'(req_i.command))
      CMD_LOAD: cls.op = ({1'b0, req_i.key_index} < KEY_LEN_W'(KEY_BYTES)) ? OP_LOAD : OP_NOP;
      CMD_INIT: cls.op = OP_INIT;
      CMD_DATA: cls.op = OP_DATA;
      CMD_NONE: cls.op = OP_NOP;
    endcase
  end

  assign cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, q_pop_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == 1'(rd_ptr_q + cnt_q))
    else $error("queue pointers disagree with fill count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDEPTH))
    else $error("queue fill count above depth");

endmodule

@@ hw/rtl/rc4_back.sv @@
// Execution engine: key store, permutation memory, key schedule and keystream.
module rc4_back
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_LEN_W-1:0] key_length_i,
  input  logic [DROP_W-1:0]    drop_count_i,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  rc4_rsp_if.source            rsp_o
);

  localparam int unsigned KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned PW = $clog2(PERM_DEPTH);
  localparam logic [KEY_LEN_W-1:0] KLEN_MAX = KEY_LEN_W'(KEY_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_KEND,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [BYTE_W-1:0]     i_q, i_d, j_q, j_d, a_q, a_d, t_q, t_d;
  logic [PW-1:0]         n_q, n_d;
  logic [KW-1:0]         kpos_q, kpos_d;
  logic [KEY_LEN_W-1:0]  len_m1_q, len_m1_d, eff_len;
  logic [DROP_W-1:0]     drop_q, drop_d;
  logic                  isd_q, isd_d;
  logic [BYTE_W-1:0]     data_q, data_d, res_q, res_d;
  logic                  pw_v_q, pw_v_d;
  logic [PW-1:0]         pw_addr_q, pw_addr_d;
  logic [BYTE_W-1:0]     pw_data_q, pw_data_d;
  logic [PW-1:0]         raddr_q;
  logic                  fwd_q, fwd_d;
  logic [BYTE_W-1:0]     fwd_val_q;
  logic                  pvld_q;
  logic [PERM_DEPTH-1:0] vld_q, vld_d;
  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;
  logic                  out_isd_q, out_isd_d;

  logic                  p_we, clr;
  logic [PW-1:0]         p_waddr, p_raddr;
  logic [BYTE_W-1:0]     p_wdata, p_rdata, rd_eff;
  logic                  k_we;
  logic [KW-1:0]         k_raddr;
  logic [BYTE_W-1:0]     k_rdata;

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_BYTES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (q_item_i.key_index[KW-1:0]),
    .wdata_i (q_item_i.data),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // An entry never written since the last clear reads as its own index.
  assign rd_eff = fwd_q ? fwd_val_q : (pvld_q ? p_rdata : raddr_q);

  always_comb begin
    if (key_length_i == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length_i > KLEN_MAX) begin
      eff_len = KLEN_MAX;
    end else begin
      eff_len = key_length_i;
    end
  end

  always_comb begin
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] ks;

    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    t_d         = t_q;
    n_d         = n_q;
    kpos_d      = kpos_q;
    len_m1_d    = len_m1_q;
    drop_d      = drop_q;
    isd_d       = isd_q;
    data_d      = data_q;
    res_d       = res_q;
    pw_v_d      = 1'b0;
    pw_addr_d   = pw_addr_q;
    pw_data_d   = pw_data_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_byte_d  = out_byte_q;
    out_isd_d   = out_isd_q;
    p_we        = pw_v_q;
    p_waddr     = pw_addr_q;
    p_wdata     = pw_data_q;
    p_raddr     = raddr_q;
    clr         = 1'b0;
    k_we        = 1'b0;
    k_raddr     = kpos_q;
    q_pop_o     = 1'b0;
    sum         = '0;
    ks          = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          res_d   = '0;
          isd_d   = 1'b0;
          unique case (q_item_i.op)
            OP_LOAD: begin
              k_we    = 1'b1;
              state_d = ST_DONE;
            end
            OP_NOP: begin
              state_d = ST_DONE;
            end
            OP_INIT: begin
              clr      = 1'b1;
              n_d      = '0;
              kpos_d   = '0;
              j_d      = '0;
              len_m1_d = KEY_LEN_W'(eff_len - 1'b1);
              state_d  = ST_K0;
            end
            OP_DATA: begin
              isd_d   = 1'b1;
              data_d  = q_item_i.data;
              state_d = ST_G0;
            end
          endcase
        end
      end
      ST_K0: begin
        p_raddr = n_q;
        k_raddr = kpos_q;
        state_d = ST_K1;
      end
      ST_K1: begin
        sum     = BYTE_W'(j_q + rd_eff + k_rdata);
        j_d     = sum;
        a_d     = rd_eff;
        p_raddr = sum;
        state_d = ST_K2;
      end
      ST_K2: begin
        p_we      = 1'b1;
        p_waddr   = n_q;
        p_wdata   = rd_eff;
        pw_v_d    = 1'b1;
        pw_addr_d = j_q;
        pw_data_d = a_q;
        n_d       = PW'(n_q + 1'b1);
        kpos_d    = (KEY_LEN_W'(kpos_q) == len_m1_q) ? '0 : KW'(kpos_q + 1'b1);
        state_d   = (n_q == PW'(PERM_DEPTH - 1)) ? ST_KEND : ST_K0;
      end
      ST_KEND: begin
        i_d     = '0;
        j_d     = '0;
        drop_d  = drop_count_i;
        state_d = (drop_count_i == '0) ? ST_DONE : ST_G0;
      end
      ST_G0: begin
        sum     = BYTE_W'(i_q + 1'b1);
        i_d     = sum;
        p_raddr = sum;
        state_d = ST_G1;
      end
      ST_G1: begin
        sum     = BYTE_W'(j_q + rd_eff);
        j_d     = sum;
        a_d     = rd_eff;
        p_raddr = sum;
        state_d = ST_G2;
      end
      ST_G2: begin
        sum       = BYTE_W'(a_q + rd_eff);
        p_we      = 1'b1;
        p_waddr   = i_q;
        p_wdata   = rd_eff;
        pw_v_d    = 1'b1;
        pw_addr_d = j_q;
        pw_data_d = a_q;
        t_d       = sum;
        p_raddr   = sum;
        if (isd_q) begin
          state_d = ST_G3;
        end else begin
          drop_d  = DROP_W'(drop_q - 1'b1);
          state_d = (drop_q == DROP_W'(1)) ? ST_DONE : ST_G0;
        end
      end
      ST_G3: begin
        ks      = (t_q == j_q) ? a_q : rd_eff;
        res_d   = data_q ^ ks;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_q;
          out_isd_d   = isd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fwd_d = p_we && (p_waddr == p_raddr);

    vld_d = vld_q;
    if (clr) begin
      vld_d = '0;
    end else if (p_we) begin
      vld_d[p_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      a_q         <= '0;
      t_q         <= '0;
      n_q         <= '0;
      kpos_q      <= '0;
      len_m1_q    <= '0;
      drop_q      <= '0;
      isd_q       <= 1'b0;
      data_q      <= '0;
      res_q       <= '0;
      pw_v_q      <= 1'b0;
      pw_addr_q   <= '0;
      pw_data_q   <= '0;
      raddr_q     <= '0;
      fwd_q       <= 1'b0;
      fwd_val_q   <= '0;
      pvld_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_isd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      a_q         <= a_d;
      t_q         <= t_d;
      n_q         <= n_d;
      kpos_q      <= kpos_d;
      len_m1_q    <= len_m1_d;
      drop_q      <= drop_d;
      isd_q       <= isd_d;
      data_q      <= data_d;
      res_q       <= res_d;
      pw_v_q      <= pw_v_d;
      pw_addr_q   <= pw_addr_d;
      pw_data_q   <= pw_data_d;
      raddr_q     <= p_raddr;
      fwd_q       <= fwd_d;
      fwd_val_q   <= p_wdata;
      pvld_q      <= vld_q[p_raddr];
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_isd_q   <= out_isd_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_byte = out_byte_q;
  assign rsp_o.is_data     = out_isd_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_v_q |-> !(state_q == ST_K2 || state_q == ST_G2))
    else $error("deferred swap write collides with a swap write");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && state_q == ST_IDLE))
    else $error("queue popped without a pending request");

  a_ack_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_isd_q) |-> (out_byte_q == '0))
    else $error("acknowledge carries a nonzero result byte");

endmodule

@@ hw/rtl/rc4_stream_cipher.sv @@
// Top level of the RC4 stream cipher with configurable keystream drop.
// Requests run one at a time; a two-entry queue accepts more.
// The one read port of the permutation memory sets the pace of the key schedule and drop.
// Reset clears per-entry valid bits so the permutation reads as the identity at once;
// both indices are zero, and the key store holds nothing until loaded.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rc4_req_if.sink               req_i,
  rc4_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [KEY_LEN_W-1:0] key_length_q;
  logic [DROP_W-1:0]    drop_count_q;
  logic                 q_valid, q_pop;
  item_t                q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RST;
      drop_count_q <= DROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_LENGTH: key_length_q <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_DROP_COUNT: drop_count_q <= cfg_data_i[DROP_W-1:0];
      endcase
    end
  end

  rc4_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  rc4_back #(.KEY_BYTES(KEY_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_length_i (key_length_q),
    .drop_count_i (drop_count_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .rsp_o        (rsp_o)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the RC4 stream cipher with configurable keystream drop.
module testbench
  import rc4_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned RANDOM_REQUESTS = 800;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              is_data;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rc4_req_if req_if ();
  rc4_rsp_if rsp_if ();

  rc4_stream_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  logic [BYTE_W-1:0]    perm [PERM_DEPTH];
  logic [BYTE_W-1:0]    key_bytes [KEY_BYTES_DEF];
  bit                   key_loaded [KEY_BYTES_DEF];
  logic [BYTE_W-1:0]    idx_i;
  logic [BYTE_W-1:0]    idx_j;
  logic [KEY_LEN_W-1:0] key_len_reg;
  logic [DROP_W-1:0]    drop_reg;

  result_t     pending_results [$];
  int unsigned error_count;
  int unsigned requests_done;
  int unsigned cycle_count;
  bit          send_gaps_on;
  bit          recv_stalls_on;
  bit          hold_pending;

  function automatic void reset_cipher_state();
    for (int n = 0; n < PERM_DEPTH; n++) begin
      perm[n] = BYTE_W'(n);
    end
    for (int n = 0; n < KEY_BYTES_DEF; n++) begin
      key_bytes[n]  = '0;
      key_loaded[n] = 1'b0;
    end
    idx_i       = '0;
    idx_j       = '0;
    key_len_reg = KEY_LEN_RST;
    drop_reg    = DROP_RST;
  endfunction

  function automatic int unsigned effective_key_len();
    if (key_len_reg == 0) return 1;
    if (key_len_reg > KEY_BYTES_DEF) return KEY_BYTES_DEF;
    return 32'(key_len_reg);
  endfunction

  function automatic bit key_ready();
    for (int n = 0; n < effective_key_len(); n++) begin
      if (!key_loaded[n]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] advance_keystream();
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    idx_i = idx_i + 8'd1;
    a = perm[idx_i];
    idx_j = idx_j + a;
    b = perm[idx_j];
    perm[idx_i] = b;
    perm[idx_j] = a;
    sum = a + b;
    return perm[sum];
  endfunction

  function automatic void schedule_key();
    int unsigned       len;
    int unsigned       kpos;
    int unsigned       n;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] t;
    len  = effective_key_len();
    kpos = 0;
    acc  = '0;
    for (n = 0; n < PERM_DEPTH; n++) begin
      perm[n] = BYTE_W'(n);
    end
    for (n = 0; n < PERM_DEPTH; n++) begin
      t = perm[n];
      acc = acc + t + key_bytes[kpos];
      perm[n] = perm[acc];
      perm[acc] = t;
      kpos++;
      if (kpos >= len) kpos = 0;
    end
    idx_i = '0;
    idx_j = '0;
    for (n = 0; n < drop_reg; n++) begin
      void'(advance_keystream());
    end
  endfunction

  function automatic result_t predict_result(cmd_e cmd, logic [BYTE_W-1:0] key_idx,
                                             logic [BYTE_W-1:0] data);
    result_t r;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        key_bytes[key_idx]  = data;
        key_loaded[key_idx] = 1'b1;
      end
      CMD_INIT: begin
        schedule_key();
      end
      CMD_DATA: begin
        r.result_byte = data ^ advance_keystream();
        r.is_data     = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_request(cmd_e cmd, logic [BYTE_W-1:0] key_idx,
                              logic [BYTE_W-1:0] data);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.key_index <= key_idx;
    req_if.data_byte <= data;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(predict_result(cmd, key_idx, data));
    if (cmd != CMD_NONE) requests_done++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_request(CMD_NONE, 8'($urandom), 8'($urandom));
      1: send_request(CMD_LOAD, 8'($urandom), 8'($urandom));
      default: send_request(CMD_DATA, 8'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic configure(logic [KEY_LEN_W-1:0] len, logic [DROP_W-1:0] drop);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_KEY_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk_i);
    cfg_idx  <= CFG_DROP_COUNT;
    cfg_data <= drop;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    key_len_reg = len;
    drop_reg    = drop;
  endtask

  task automatic test_directed_requests();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_request(CMD_DATA, 8'h00, 8'h00);
    send_request(CMD_DATA, 8'hFF, 8'hFF);
    send_request(CMD_NONE, 8'hFF, 8'hFF);
    for (int n = 0; n < 16; n++) begin
      send_request(CMD_LOAD, BYTE_W'(n),
                   (n == 0) ? 8'hFF : (n == 15) ? 8'h00 : 8'($urandom));
    end
    send_request(CMD_LOAD, 8'hFF, 8'h5A);
    send_request(CMD_INIT, 8'h00, 8'h00);
    send_request(CMD_DATA, 8'h00, 8'h00);
    send_request(CMD_DATA, 8'h00, 8'hFF);
    send_request(CMD_DATA, 8'hFF, 8'h81);
  endtask

  task automatic test_config_extremes();
    wait_results_drained();
    configure('0, '0);
    send_request(CMD_INIT, 8'($urandom), 8'($urandom));
    send_request(CMD_DATA, 8'($urandom), 8'h3C);
    send_request(CMD_DATA, 8'($urandom), 8'hC3);
    for (int n = 0; n < KEY_BYTES_DEF; n++) begin
      send_request(CMD_LOAD, BYTE_W'(n), 8'($urandom));
    end
    wait_results_drained();
    configure('1, '1);
    send_request(CMD_INIT, 8'($urandom), 8'($urandom));
    send_request(CMD_DATA, 8'($urandom), 8'($urandom));
    send_request(CMD_DATA, 8'($urandom), 8'($urandom));
    wait_results_drained();
    configure(KEY_LEN_W'(KEY_BYTES_DEF), 16'd1);
    send_request(CMD_INIT, 8'($urandom), 8'($urandom));
    send_request(CMD_DATA, 8'($urandom), 8'($urandom));
  endtask

  // The result side stops for a long stretch so the request queue fills and stalls.
  task automatic test_backpressure();
    wait_results_drained();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_pending   = 1'b1;
    for (int n = 0; n < 16; n++) begin
      send_request(CMD_DATA, 8'($urandom), 8'($urandom));
    end
    wait_results_drained();
  endtask

  task automatic test_random_streams();
    int unsigned          start;
    int unsigned          len_sel;
    int unsigned          fresh;
    int unsigned          data_count;
    int unsigned          n;
    logic [KEY_LEN_W-1:0] new_len;
    logic [DROP_W-1:0]    new_drop;
    start = requests_done;
    while (requests_done - start < RANDOM_REQUESTS) begin
      send_gaps_on   = $urandom_range(0, 3) != 0;
      recv_stalls_on = $urandom_range(0, 3) != 0;
      len_sel = $urandom_range(0, 9);
      if (len_sel <= 5) new_len = KEY_LEN_W'($urandom_range(1, 32));
      else if (len_sel == 6) new_len = '0;
      else if (len_sel == 7) new_len = KEY_LEN_W'($urandom_range(257, 511));
      else new_len = KEY_LEN_W'($urandom_range(33, 256));
      new_drop = ($urandom_range(0, 4) != 0) ? DROP_W'($urandom_range(0, 64))
                                             : DROP_W'($urandom_range(65, 4095));
      wait_results_drained();
      configure(new_len, new_drop);
      fresh = $urandom_range(1, 40);
      for (n = 0; n < effective_key_len(); n++) begin
        if (n >= fresh && key_loaded[n]) continue;
        if ($urandom_range(0, 19) == 0 && key_ready()) break;
        if ($urandom_range(0, 7) == 0) send_noise();
        send_request(CMD_LOAD, BYTE_W'(n), 8'($urandom));
      end
      send_request(CMD_INIT, 8'($urandom), 8'($urandom));
      data_count = $urandom_range(10, 40);
      for (n = 0; n < data_count; n++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        if ($urandom_range(0, 49) == 0 && key_ready())
          send_request(CMD_INIT, 8'($urandom), 8'($urandom));
        send_request(CMD_DATA, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        stall_left = recv_stalls_on ? $urandom_range(0, 15) : 0;
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got byte %02h is_data %0b",
                 $time, rsp_if.result_byte, rsp_if.is_data);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_byte !== want.result_byte) begin
          error_count++;
          $display("%0t: result_byte mismatch: expected %02h, got %02h",
                   $time, want.result_byte, rsp_if.result_byte);
        end
        if (rsp_if.is_data !== want.is_data) begin
          error_count++;
          $display("%0t: is_data mismatch: expected %0b, got %0b",
                   $time, want.is_data, rsp_if.is_data);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    error_count    = 0;
    requests_done  = 0;
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_pending   = 1'b0;
    reset_cipher_state();
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_NONE;
    req_if.key_index <= '0;
    req_if.data_byte <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_KEY_LENGTH;
    cfg_data         <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_requests();
    test_config_extremes();
    test_backpressure();
    test_random_streams();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
